@@ hw/rtl/dpc_pkg.sv @@
// ----------------------------------------------------------------------------
// dpc_pkg: shared types and constants
// Codes, tick positions and the per-channel command struct for the
// two-channel polynomial counter tone generator.
// ----------------------------------------------------------------------------
package dpc_pkg;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 8;
    localparam int SAMPLE_W = 5;
    localparam int VOL_W    = 4;

    localparam logic       OP_TICK  = 1'b0;
    localparam logic       OP_WRITE = 1'b1;

    localparam logic [1:0] REG_CTL  = 2'd0;
    localparam logic [1:0] REG_FREQ = 2'd1;
    localparam logic [1:0] REG_VOL  = 2'd2;

    localparam logic [7:0] POS_PHASE0_A = 8'd9;
    localparam logic [7:0] POS_PHASE0_B = 8'd81;
    localparam logic [7:0] POS_PHASE1_A = 8'd37;
    localparam logic [7:0] POS_PHASE1_B = 8'd149;

    localparam logic [4:0] DIV_MAX = 5'h1F;

    typedef struct packed {
        logic       op;
        logic [7:0] clock_pos;
        logic       chan_sel;
        logic [1:0] reg_sel;
        logic [7:0] write_data;
    } dpc_item_t;

    typedef struct packed {
        logic phase0;
        logic phase1;
        logic wr_ctl;
        logic wr_freq;
        logic wr_vol;
    } dpc_cmd_t;

endpackage

@@ hw/rtl/dpc_chan.sv @@
// ----------------------------------------------------------------------------
// dpc_chan: one audio channel
// Divider, noise and pulse counters with their control, frequency and
// volume registers; gives the channel output after the current command.
// ----------------------------------------------------------------------------
module dpc_chan (
    input  logic              aclk,
    input  logic              aresetn,
    input  dpc_pkg::dpc_cmd_t cmd,
    input  logic [7:0]        write_data,
    output logic [3:0]        sample_next
);
    import dpc_pkg::*;

    logic [3:0] ctl_reg,   ctl_next;
    logic [4:0] freq_reg,  freq_next;
    logic [3:0] vol_reg,   vol_next;
    logic [4:0] div_reg,   div_next;
    logic [4:0] noise_reg, noise_next;
    logic [3:0] pulse_reg, pulse_next;
    logic       step_reg,  step_next;
    logic       nlb_reg,   nlb_next;
    logic       hold_reg,  hold_next;
    logic       feed_reg,  feed_next;
    logic       fb;

    always_comb begin
        ctl_next   = ctl_reg;
        freq_next  = freq_reg;
        vol_next   = vol_reg;
        div_next   = div_reg;
        noise_next = noise_reg;
        pulse_next = pulse_reg;
        step_next  = step_reg;
        nlb_next   = nlb_reg;
        hold_next  = hold_reg;
        feed_next  = feed_reg;
        fb         = 1'b0;

        if (cmd.wr_ctl) begin
            ctl_next = write_data[3:0];
        end
        if (cmd.wr_freq) begin
            freq_next = write_data[4:0];
        end
        if (cmd.wr_vol) begin
            vol_next = write_data[3:0];
        end

        if (cmd.phase0) begin
            if (step_reg) begin
                nlb_next = noise_reg[0];
                case (ctl_reg[1:0])
                    2'b00, 2'b01: hold_next = 1'b0;
                    2'b10:        hold_next = (noise_reg[4:1] != 4'b0001);
                    default:      hold_next = !noise_reg[0];
                endcase
                if (ctl_reg[1:0] == 2'b00) begin
                    feed_next = (pulse_reg[0] ^ noise_reg[0])
                             || (noise_reg == 5'd0 && pulse_reg == 4'hA)
                             || (ctl_reg[3:2] == 2'b00);
                end else begin
                    feed_next = (noise_reg[2] ^ noise_reg[0]) || (noise_reg == 5'd0);
                end
            end
            step_next = (div_reg == freq_reg);
            if (div_reg == freq_reg || div_reg == DIV_MAX) begin
                div_next = 5'd0;
            end else begin
                div_next = div_reg + 5'd1;
            end
        end

        if (cmd.phase1 && step_reg) begin
            case (ctl_reg[3:2])
                2'b00:   fb = (pulse_reg[1] ^ pulse_reg[0]) && (pulse_reg != 4'hA)
                              && (ctl_reg[1:0] != 2'b00);
                2'b01:   fb = !pulse_reg[3];
                2'b10:   fb = !nlb_reg;
                default: fb = !(pulse_reg[1] || (pulse_reg[3:1] == 3'b000));
            endcase
            noise_next = {feed_reg, noise_reg[4:1]};
            if (!hold_reg) begin
                pulse_next = {fb, ~pulse_reg[3:1]};
            end
        end

        sample_next = pulse_next[0] ? vol_next : 4'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg   <= '0;
            freq_reg  <= '0;
            vol_reg   <= '0;
            div_reg   <= '0;
            noise_reg <= '0;
            pulse_reg <= '0;
            step_reg  <= 1'b0;
            nlb_reg   <= 1'b0;
            hold_reg  <= 1'b0;
            feed_reg  <= 1'b0;
        end else begin
            ctl_reg   <= ctl_next;
            freq_reg  <= freq_next;
            vol_reg   <= vol_next;
            div_reg   <= div_next;
            noise_reg <= noise_next;
            pulse_reg <= pulse_next;
            step_reg  <= step_next;
            nlb_reg   <= nlb_next;
            hold_reg  <= hold_next;
            feed_reg  <= feed_next;
        end
    end

endmodule

@@ hw/rtl/dual_poly_counter_tone_gen.sv @@
// ----------------------------------------------------------------------------
// dual_poly_counter_tone_gen: two-channel polynomial counter tone generator
// Takes color clock ticks and audio register writes, runs both channels and
// returns the mixed sample after every beat.
//
//   channel | dir | tdata                                        | tuser
//   s_      | in  | clock_pos[7:0] chan_sel[8] reg_sel[10:9]      | op
//           |     | write_data[18:11], zero fill [23:19]         |
//   m_      | out | mixed_sample[4:0], zero fill [7:5]           | -
//
// One beat per cycle sustained while m_ does not stall; a beat's result is offered
// on m_ once it moves from the input register into the result register (the
// channel update happens on that same move), and is taken when m_tready is high.
// Reset (aresetn low, synchronous) clears all channel state and both stages.
// A stall on m_ holds the result register and backs up into the input
// register; s_tready drops only when both are full.
// ----------------------------------------------------------------------------
module dual_poly_counter_tone_gen (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // clock_pos, chan_sel, reg_sel, write_data (lowest bit first)
    input  logic [dpc_pkg::S_DATA_W-1:0] s_tdata,
    // op
    input  logic                         s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // mixed_sample
    output logic [dpc_pkg::M_DATA_W-1:0] m_tdata
);
    import dpc_pkg::*;

    dpc_item_t             item_reg;
    logic                  item_valid_reg;
    logic                  out_valid_reg;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic                  advance;
    logic                  fire;
    logic                  is_phase0;
    logic                  is_phase1;
    dpc_cmd_t              cmd [2];
    logic [VOL_W-1:0]      chan_out [2];
    logic [SAMPLE_W-1:0]   mix_next;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !item_valid_reg || advance;
    assign fire     = item_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tready) begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.op         <= s_tuser;
            item_reg.clock_pos  <= s_tdata[7:0];
            item_reg.chan_sel   <= s_tdata[8];
            item_reg.reg_sel    <= s_tdata[10:9];
            item_reg.write_data <= s_tdata[18:11];
        end
    end

    assign is_phase0 = (item_reg.op == OP_TICK)
                    && (item_reg.clock_pos == POS_PHASE0_A
                     || item_reg.clock_pos == POS_PHASE0_B);
    assign is_phase1 = (item_reg.op == OP_TICK)
                    && (item_reg.clock_pos == POS_PHASE1_A
                     || item_reg.clock_pos == POS_PHASE1_B);

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            cmd[k].phase0  = fire && is_phase0;
            cmd[k].phase1  = fire && is_phase1;
            cmd[k].wr_ctl  = 1'b0;
            cmd[k].wr_freq = 1'b0;
            cmd[k].wr_vol  = 1'b0;
            if (fire && item_reg.op == OP_WRITE && item_reg.chan_sel == k[0]) begin
                unique case (item_reg.reg_sel)
                    REG_CTL:  cmd[k].wr_ctl  = 1'b1;
                    REG_FREQ: cmd[k].wr_freq = 1'b1;
                    REG_VOL:  cmd[k].wr_vol  = 1'b1;
                    default:  ;
                endcase
            end
        end
    end

    dpc_chan u_chan0 (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd[0]),
        .write_data  (item_reg.write_data),
        .sample_next (chan_out[0])
    );

    dpc_chan u_chan1 (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd[1]),
        .write_data  (item_reg.write_data),
        .sample_next (chan_out[1])
    );

    assign mix_next = {1'b0, chan_out[0]} + {1'b0, chan_out[1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            sample_reg <= mix_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - SAMPLE_W){1'b0}}, sample_reg};

`ifndef SYNTHESIS
    a_sample_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (sample_reg <= 5'd30))
        else $error("mixed sample out of range");

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd[0].phase0, cmd[0].phase1, cmd[0].wr_ctl, cmd[0].wr_freq,
                  cmd[0].wr_vol, cmd[1].wr_ctl, cmd[1].wr_freq, cmd[1].wr_vol}))
        else $error("more than one channel command in a cycle");

    a_hold_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid_reg && !advance) |=> (item_valid_reg && $stable(item_reg)))
        else $error("input stage lost a stalled beat");

    a_fire_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> out_valid_reg)
        else $error("processed beat did not reach the result register");
`endif

endmodule
